// File: src/hcr_pkg.sv
// Shared types and constants of the Harris corner response block.
`timescale 1ns / 1ps
package hcr_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_SENS = 2'd2;

  localparam logic [9:0]  COLS_RST = 10'd640;
  localparam logic [11:0] ROWS_RST = 12'd480;
  localparam logic [15:0] SENS_RST = 16'd2621;

  localparam int PIX_W  = 8;
  localparam int SQ_W   = 21;   // squared gradient
  localparam int CR_W   = 22;   // gradient cross product, signed
  localparam int SUM_W  = 24;   // window sum of squares
  localparam int SXY_W  = 26;   // window sum of cross products, signed
  localparam int RESP_W = 48;
  localparam int Q_DEPTH = 8;
  localparam int QCNT_W  = 4;

  // One window sum set handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0]        sxx;
    logic [SUM_W-1:0]        syy;
    logic signed [SXY_W-1:0] sxy;
    logic [11:0]             row;
    logic [9:0]              col;
    logic                    last;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MPOS, B_MA2, B_MT2, B_MKL, B_MKH, B_KT, B_RES
  } back_state_e;

endpackage

// File: src/hcr_front.sv
// Front end: pixel counters, line buffers, windows, gradients and window sums.
`timescale 1ns / 1ps
module hcr_front #(
  parameter int MAX_LINE = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               pixel_i,
  input  logic [9:0]               frame_cols_i,
  input  logic [11:0]              frame_rows_i,
  input  logic [hcr_pkg::QCNT_W-1:0] q_count_i,
  output logic                     push_o,
  output hcr_pkg::item_t           push_item_o
);
  import hcr_pkg::*;

  localparam int AW = $clog2(MAX_LINE);
  localparam int COLS_HI = (MAX_LINE - 2 < 1022) ? MAX_LINE - 2 : 1022;

  logic [9:0]  cols_eff;
  logic [11:0] rows_eff;
  logic [11:0] row_q, row_d;
  logic [9:0]  col_q, col_d;
  logic [12:0] r_t;
  logic [10:0] c_t;
  logic [11:0] r_a;
  logic [9:0]  c_a;
  logic        last_a;
  logic        accept;

  logic [PIX_W-1:0] mem_pix0_q [MAX_LINE];
  logic [PIX_W-1:0] mem_pix1_q [MAX_LINE];
  logic [PIX_W-1:0] pix_rd0_q, pix_rd1_q;
  logic [63:0]      mem_prd0_q [MAX_LINE];
  logic [63:0]      mem_prd1_q [MAX_LINE];
  logic [63:0]      prd_rd0_q, prd_rd1_q;

  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [11:0]      s1_r_q, s2_r_q, s3_r_q, s4_r_q;
  logic [9:0]       s1_c_q, s2_c_q, s3_c_q, s4_c_q;
  logic             s1_l_q, s2_l_q, s3_l_q, s4_l_q;
  logic             s3_act_q, s3_par_q, s4_emit_q;
  logic [SQ_W-1:0]  s3_qx_q, s3_qy_q;
  logic [CR_W-1:0]  s3_qxy_q;

  logic [PIX_W-1:0] win_q [3][3];
  logic [SQ_W-1:0]  wsx_q [3][3];
  logic [SQ_W-1:0]  wsy_q [3][3];
  logic [CR_W-1:0]  wcr_q [3][3];

  logic [10:0]        top_s, bot_s, lef_s, rig_s;
  logic signed [11:0] gx, gy;
  logic signed [23:0] gxx, gyy, gxy;
  logic               act_c;
  logic [11:0]        pr_c;
  logic [9:0]         pc_c;
  logic [2:0]         inflight;
  logic [SUM_W-1:0]   sum_x, sum_y;
  logic signed [SXY_W-1:0] sum_c;

  // Clamp frame size
  always_comb begin
    cols_eff = frame_cols_i;
    if (cols_eff < 10'd3) cols_eff = 10'd3;
    if (cols_eff > 10'(COLS_HI)) cols_eff = 10'(COLS_HI);
    rows_eff = frame_rows_i;
    if (rows_eff < 12'd3) rows_eff = 12'd3;
    if (rows_eff > 12'd4094) rows_eff = 12'd4094;
  end

  // Hold input while queue space is not guaranteed for every item in flight
  assign inflight   = 3'(s1_v_q) + 3'(s2_v_q) + 3'(s3_v_q) + 3'(s4_v_q);
  assign in_stall_o = (5'(q_count_i) + 5'(inflight)) >= 5'(Q_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  // Position of this pixel and of the next one
  always_comb begin
    r_t = {1'b0, row_q};
    c_t = {1'b0, col_q};
    if (c_t > 11'(cols_eff) + 11'd1) begin
      c_t = '0;
      r_t = r_t + 13'd1;
    end
    if (r_t > 13'(rows_eff) + 13'd1) r_t = '0;
    r_a    = r_t[11:0];
    c_a    = c_t[9:0];
    last_a = (r_a == rows_eff + 12'd1) && (c_a == cols_eff + 10'd1);
    if (c_a >= cols_eff + 10'd1) begin
      col_d = '0;
      row_d = (r_a >= rows_eff + 12'd1) ? '0 : r_a + 12'd1;
    end else begin
      col_d = c_a + 10'd1;
      row_d = r_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Pixel line buffers: read both rows, overwrite the older one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_rd0_q <= mem_pix0_q[AW'(c_a)];
      pix_rd1_q <= mem_pix1_q[AW'(c_a)];
      if (r_a[0]) mem_pix1_q[AW'(c_a)] <= pixel_i;
      else        mem_pix0_q[AW'(c_a)] <= pixel_i;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q <= pixel_i;
    s1_r_q  <= r_a;
    s1_c_q  <= c_a;
    s1_l_q  <= last_a;
    s2_r_q  <= s1_r_q;
    s2_c_q  <= s1_c_q;
    s2_l_q  <= s1_l_q;
  end

  // Advance pixel window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) win_q[k][j] <= '0;
    end else if (s1_v_q) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= s1_r_q[0] ? pix_rd1_q : pix_rd0_q;
      win_q[1][2] <= s1_r_q[0] ? pix_rd0_q : pix_rd1_q;
      win_q[2][2] <= s1_px_q;
    end
  end

  // Gradients and their products
  always_comb begin
    bot_s = 11'(win_q[2][0]) + {2'b0, win_q[2][1], 1'b0} + 11'(win_q[2][2]);
    top_s = 11'(win_q[0][0]) + {2'b0, win_q[0][1], 1'b0} + 11'(win_q[0][2]);
    rig_s = 11'(win_q[0][2]) + {2'b0, win_q[1][2], 1'b0} + 11'(win_q[2][2]);
    lef_s = 11'(win_q[0][0]) + {2'b0, win_q[1][0], 1'b0} + 11'(win_q[2][0]);
    gx    = $signed({1'b0, bot_s}) - $signed({1'b0, top_s});
    gy    = $signed({1'b0, rig_s}) - $signed({1'b0, lef_s});
    gxx   = gx * gx;
    gyy   = gy * gy;
    gxy   = gx * gy;
    act_c = (s2_r_q >= 12'd2) && (s2_c_q >= 10'd2);
    pr_c  = s2_r_q - 12'd1;
    pc_c  = s2_c_q - 10'd1;
  end

  // Product line buffers
  always_ff @(posedge clk_i) begin
    if (s2_v_q && act_c) begin
      prd_rd0_q <= mem_prd0_q[AW'(pc_c)];
      prd_rd1_q <= mem_prd1_q[AW'(pc_c)];
      if (pr_c[0]) mem_prd1_q[AW'(pc_c)] <= {gxx[SQ_W-1:0], gyy[SQ_W-1:0], gxy[CR_W-1:0]};
      else         mem_prd0_q[AW'(pc_c)] <= {gxx[SQ_W-1:0], gyy[SQ_W-1:0], gxy[CR_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    s3_act_q  <= act_c;
    s3_par_q  <= pr_c[0];
    s3_qx_q   <= gxx[SQ_W-1:0];
    s3_qy_q   <= gyy[SQ_W-1:0];
    s3_qxy_q  <= gxy[CR_W-1:0];
    s3_r_q    <= s2_r_q;
    s3_c_q    <= s2_c_q;
    s3_l_q    <= s2_l_q;
    s4_emit_q <= s3_act_q && (s3_r_q >= 12'd4) && (s3_c_q >= 10'd4);
    s4_r_q    <= s3_r_q - 12'd2;
    s4_c_q    <= s3_c_q - 10'd2;
    s4_l_q    <= s3_l_q;
  end

  // Advance product window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) begin
          wsx_q[k][j] <= '0;
          wsy_q[k][j] <= '0;
          wcr_q[k][j] <= '0;
        end
    end else if (s3_v_q && s3_act_q) begin
      for (int k = 0; k < 3; k++) begin
        wsx_q[k][0] <= wsx_q[k][1];
        wsx_q[k][1] <= wsx_q[k][2];
        wsy_q[k][0] <= wsy_q[k][1];
        wsy_q[k][1] <= wsy_q[k][2];
        wcr_q[k][0] <= wcr_q[k][1];
        wcr_q[k][1] <= wcr_q[k][2];
      end
      {wsx_q[0][2], wsy_q[0][2], wcr_q[0][2]} <= s3_par_q ? prd_rd1_q : prd_rd0_q;
      {wsx_q[1][2], wsy_q[1][2], wcr_q[1][2]} <= s3_par_q ? prd_rd0_q : prd_rd1_q;
      wsx_q[2][2] <= s3_qx_q;
      wsy_q[2][2] <= s3_qy_q;
      wcr_q[2][2] <= s3_qxy_q;
    end
  end

  // Sum the window
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    sum_c = '0;
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) begin
        sum_x = sum_x + SUM_W'(wsx_q[k][j]);
        sum_y = sum_y + SUM_W'(wsy_q[k][j]);
        sum_c = sum_c + SXY_W'($signed(wcr_q[k][j]));
      end
  end

  assign push_o           = s4_v_q && s4_emit_q;
  assign push_item_o.sxx  = sum_x;
  assign push_item_o.syy  = sum_y;
  assign push_item_o.sxy  = sum_c;
  assign push_item_o.row  = s4_r_q;
  assign push_item_o.col  = s4_c_q;
  assign push_item_o.last = s4_l_q;

endmodule

// File: src/hcr_queue.sv
// Short queue of window sums between front and back.
`timescale 1ns / 1ps
module hcr_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  hcr_pkg::item_t             push_item_i,
  input  logic                       pop_i,
  output hcr_pkg::item_t             head_o,
  output logic                       empty_o,
  output logic [hcr_pkg::QCNT_W-1:0] count_o
);
  import hcr_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  item_t             slot_q [Q_DEPTH];
  logic [PW-1:0]     wp_q, rp_q;
  logic [QCNT_W-1:0] cnt_q;

  assign head_o  = slot_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= push_item_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

endmodule

// File: src/hcr_back.sv
// Back end: Harris response from window sums on one shared multiplier.
`timescale 1ns / 1ps
module hcr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hcr_pkg::item_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  logic [15:0]                 sens_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [hcr_pkg::RESP_W-1:0] response_o,
  output logic [11:0]                 out_row_o,
  output logic [9:0]                  out_col_o,
  output logic                        frame_last_o
);
  import hcr_pkg::*;

  back_state_e state_q, state_d;

  logic [SUM_W-1:0] sxx_q, syy_q;
  logic [24:0]      trace_q, axy_q;
  logic [11:0]      row_q;
  logic [9:0]       col_q;
  logic             last_q;
  logic [47:0]      pos_q;
  logic [49:0]      a2_q, t2_q, kt_q;
  logic [40:0]      kl_q, kh_q;
  logic [24:0]      ma, mb;
  logic [49:0]      mp;
  logic [65:0]      kfull;
  logic signed [52:0] diff;
  logic signed [RESP_W-1:0] resp_c;
  logic             out_free;
  logic [SXY_W-1:0] sxy_abs;

  assign out_free = !out_valid_o || !out_stall_i;
  assign sxy_abs  = head_i.sxy[SXY_W-1] ? -head_i.sxy : head_i.sxy;

  // Next state and control
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_MPOS;
        end
      end
      B_MPOS: state_d = B_MA2;
      B_MA2:  state_d = B_MT2;
      B_MT2:  state_d = B_MKL;
      B_MKL:  state_d = B_MKH;
      B_MKH:  state_d = B_KT;
      B_KT:   state_d = B_RES;
      B_RES: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= B_IDLE;
    else         state_q <= state_d;
  end

  // Select multiplier operands
  always_comb begin
    case (state_q)
      B_MPOS: begin ma = 25'(sxx_q);   mb = 25'(syy_q); end
      B_MA2:  begin ma = axy_q;        mb = axy_q;      end
      B_MT2:  begin ma = trace_q;      mb = trace_q;    end
      B_MKL:  begin ma = t2_q[24:0];   mb = 25'(sens_i); end
      B_MKH:  begin ma = t2_q[49:25];  mb = 25'(sens_i); end
      default: begin ma = '0;          mb = '0;         end
    endcase
    mp = ma * mb;
  end

  // Rounded k term, then difference with saturation at both ends
  always_comb begin
    kfull = {kh_q, 25'b0} + 66'(kl_q) + 66'd32768;
    diff  = $signed({5'b0, pos_q}) - $signed({3'b0, a2_q}) - $signed({3'b0, kt_q});
    if (diff < -$signed(53'h800000000000))
      resp_c = {1'b1, {(RESP_W-1){1'b0}}};
    else if (diff > $signed(53'h7FFFFFFFFFFF))
      resp_c = {1'b0, {(RESP_W-1){1'b1}}};
    else
      resp_c = diff[RESP_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        sxx_q   <= head_i.sxx;
        syy_q   <= head_i.syy;
        trace_q <= 25'(head_i.sxx) + 25'(head_i.syy);
        axy_q   <= sxy_abs[24:0];
        row_q   <= head_i.row;
        col_q   <= head_i.col;
        last_q  <= head_i.last;
      end
      B_MPOS: pos_q <= mp[47:0];
      B_MA2:  a2_q  <= mp;
      B_MT2:  t2_q  <= mp;
      B_MKL:  kl_q  <= mp[40:0];
      B_MKH:  kh_q  <= mp[40:0];
      B_KT:   kt_q  <= kfull[65:16];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == B_RES && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_RES && out_free) begin
      response_o   <= resp_c;
      out_row_o    <= row_q;
      out_col_o    <= col_q;
      frame_last_o <= last_q;
    end
  end

endmodule

// File: src/harris_corner_response.sv
// Top level of the streaming 3x3 Harris corner response block.
//
//   channel | direction | handshake               | payload
//   pixel   | in        | in_valid_i / in_stall_o  | pixel_i
//   result  | out       | out_valid_o / out_stall_i| response_o, out_row_o, out_col_o,
//           |           |                         | frame_last_o
//   config  | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// The front end takes one pixel per cycle while in_stall_o is low; each result reaches the result
// port through the front-end stages, the queue and the back end.
// The back end works each result through MPOS, MA2, MT2, MKL, MKH, KT and RES on one shared
// 25x25 multiplier and pops the next item only from IDLE, after the last result has left RES.
// An 8-entry queue sits between them; the front stalls when it cannot guarantee space.
// Reset clears counters, windows and control; line buffers need no clearing.
`timescale 1ns / 1ps
module harris_corner_response #(
  parameter int MAX_LINE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [47:0] response_o,
  output logic [11:0] out_row_o,
  output logic [9:0]  out_col_o,
  output logic        frame_last_o
);
  import hcr_pkg::*;

  logic [9:0]  cols_q;
  logic [11:0] rows_q;
  logic [15:0] sens_q;

  logic              push;
  item_t             push_item, head;
  logic              pop, empty;
  logic [QCNT_W-1:0] count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RST;
      rows_q <= ROWS_RST;
      sens_q <= SENS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLS: cols_q <= cfg_data_i[9:0];
        CFG_ROWS: rows_q <= cfg_data_i[11:0];
        CFG_SENS: sens_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hcr_front #(.MAX_LINE(MAX_LINE)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .frame_cols_i(cols_q),
    .frame_rows_i(rows_q),
    .q_count_i   (count),
    .push_o      (push),
    .push_item_o (push_item)
  );

  hcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .count_o    (count)
  );

  hcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .sens_i      (sens_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .response_o  (response_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// File: src/hcr_checker.sv
// Port-level checks of the Harris corner response block, bound to the top level.
`timescale 1ns / 1ps
module hcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] response_o,
  input logic [11:0] out_row_o,
  input logic [9:0]  out_col_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(response_o))
    else $error("stalled result changed");

  // Results only at interior positions
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_row_o >= 12'd2 && out_col_o >= 10'd2 &&
                    out_row_o <= 12'd4093 && out_col_o <= 10'd1021)
    else $error("result outside the interior");

  // No result right out of reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present after reset");

endmodule

bind harris_corner_response hcr_checker u_hcr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .response_o (response_o),
  .out_row_o  (out_row_o),
  .out_col_o  (out_col_o)
);

// File: bench/harris_corner_response_tb.sv
// Self-checking testbench of the streaming Harris corner response block.
`timescale 1ns / 1ps
module harris_corner_response_tb;
  import hcr_pkg::*;

  localparam int LINE      = 1024;
  localparam int DRAIN_CYC = 40;
  localparam int STALL_LIM = 5000;
  localparam int RAND_PIX  = 1350;
  localparam logic [63:0] RESP_TOP = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] resp;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } corner_t;

  typedef struct {
    logic [7:0] px;
    bit         typed;
    corner_t    want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_COLS;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [47:0] response_o;
  logic [11:0] out_row_o;
  logic [9:0]  out_col_o;
  logic        frame_last_o;

  harris_corner_response u_dut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state: its own copy of the configuration, lines, windows, counters
  int unsigned cols_reg = COLS_RST, rows_reg = ROWS_RST, sens_reg = SENS_RST;
  int unsigned pix_line[2*LINE];
  int unsigned sqx_line[2*LINE];
  int unsigned sqy_line[2*LINE];
  int          xy_line[2*LINE];
  int          pix_win[3][3];
  longint      prod_win[3][3][3];
  int unsigned row_cnt, col_cnt;

  corner_t pending_resp[$];
  bit      calm = 1'b0;
  int      errors = 0, pixels_sent = 0, results_seen = 0, frames_run = 0;
  int      quiet_cycles = 0;
  dir_row_t dir_tbl[25];

  function automatic logic [47:0] harris_resp(longint unsigned sxx, longint unsigned syy,
                                              longint sxy);
    logic [127:0] wide;
    logic [63:0]  tr, axy, pos, kt, neg, v;
    tr   = sxx + syy;
    axy  = (sxy < 0) ? 64'(-sxy) : 64'(sxy);
    pos  = sxx * syy;
    wide = {64'd0, tr * 64'(sens_reg)} * {64'd0, tr};
    wide = (wide + 128'd32768) >> 16;
    // k term too large for the signed range: pin at the negative limit
    if (wide >= (128'd1 << 63)) return 48'h8000_0000_0000;
    kt  = wide[63:0];
    neg = axy * axy + kt;
    if (pos >= neg) begin
      v = pos - neg;
      return (v > RESP_TOP) ? RESP_TOP[47:0] : v[47:0];
    end
    v = neg - pos;
    if (v > RESP_TOP + 64'd1) v = RESP_TOP + 64'd1;
    v = -v;
    return v[47:0];
  endfunction

  // Advance the predictor by one pixel and queue the result it causes
  function automatic void corner_predict(input logic [7:0] px);
    int unsigned cc, rr, r, c, pr, pc, here, prev;
    int gx, gy;
    longint unsigned sxx, syy;
    longint sxy;
    corner_t e;
    cc = (cols_reg < 3) ? 3 : (cols_reg > 1022) ? 1022 : cols_reg;
    rr = (rows_reg < 3) ? 3 : (rows_reg > 4094) ? 4094 : rows_reg;
    r = row_cnt;
    c = col_cnt;
    // restart counters that lie beyond a shrunk frame
    if (c > cc + 1) begin
      c = 0;
      r++;
    end
    if (r > rr + 1) r = 0;
    for (int k = 0; k < 3; k++) begin
      pix_win[k][0] = pix_win[k][1];
      pix_win[k][1] = pix_win[k][2];
    end
    pix_win[0][2] = pix_line[(r & 1) * LINE + c];
    pix_win[1][2] = pix_line[((r + 1) & 1) * LINE + c];
    pix_win[2][2] = px;
    pix_line[(r & 1) * LINE + c] = px;
    if (r >= 2 && c >= 2) begin
      gx = (pix_win[2][0] + 2 * pix_win[2][1] + pix_win[2][2])
         - (pix_win[0][0] + 2 * pix_win[0][1] + pix_win[0][2]);
      gy = (pix_win[0][2] + 2 * pix_win[1][2] + pix_win[2][2])
         - (pix_win[0][0] + 2 * pix_win[1][0] + pix_win[2][0]);
      pr = r - 1;
      pc = c - 1;
      here = (pr & 1) * LINE + pc;
      prev = ((pr + 1) & 1) * LINE + pc;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) begin
          prod_win[k][0][j] = prod_win[k][1][j];
          prod_win[k][1][j] = prod_win[k][2][j];
        end
      prod_win[0][2][0] = sqx_line[here];
      prod_win[0][2][1] = sqy_line[here];
      prod_win[0][2][2] = xy_line[here];
      prod_win[1][2][0] = sqx_line[prev];
      prod_win[1][2][1] = sqy_line[prev];
      prod_win[1][2][2] = xy_line[prev];
      prod_win[2][2][0] = gx * gx;
      prod_win[2][2][1] = gy * gy;
      prod_win[2][2][2] = gx * gy;
      sqx_line[here] = gx * gx;
      sqy_line[here] = gy * gy;
      xy_line[here]  = gx * gy;
      if (r >= 4 && c >= 4) begin
        sxx = 0;
        syy = 0;
        sxy = 0;
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++) begin
            sxx += prod_win[k][j][0];
            syy += prod_win[k][j][1];
            sxy += prod_win[k][j][2];
          end
        e.resp = harris_resp(sxx, syy, sxy);
        e.row  = 12'(r - 2);
        e.col  = 10'(c - 2);
        e.last = (r == rr + 1 && c == cc + 1);
        pending_resp.push_back(e);
      end
    end
    if (c >= cc + 1) begin
      c = 0;
      r = (r >= rr + 1) ? 0 : r + 1;
    end else begin
      c++;
    end
    row_cnt = r;
    col_cnt = c;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Offer one pixel, after a random gap unless calm is set, and hold it until accepted
  task automatic send_pixel(input logic [7:0] px, input bit typed, input corner_t want);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (in_stall_o);
    corner_predict(px);
    pixels_sent++;
    if (typed) begin
      void'(pending_resp.pop_back());
      pending_resp.push_back(want);
    end
  endtask

  // Write one register once every expected item has left the block
  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_COLS: cols_reg = data[9:0];
      CFG_ROWS: rows_reg = data[11:0];
      CFG_SENS: sens_reg = data;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_pixel(int mode, int r, int c);
    case (mode)
      0: return 8'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'(r * 23 + c * 11 + $urandom_range(0, 15));
    endcase
  endfunction

  // Stream pixels until the predicted counters close the frame
  task automatic stream_frame(input int mode);
    corner_t none;
    none = '{default: '0};
    do send_pixel(pick_pixel(mode, row_cnt, col_cnt), 1'b0, none);
    while (row_cnt != 0 || col_cnt != 0);
    frames_run++;
  endtask

  task automatic setup_frame(input int unsigned cols, input int unsigned rows,
                             input int unsigned sens);
    write_cfg(CFG_COLS, {6'($urandom), 10'(cols)});
    write_cfg(CFG_ROWS, {4'($urandom), 12'(rows)});
    write_cfg(CFG_SENS, 16'(sens));
  endtask

  // Random stall on the result side
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 37);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    corner_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_resp.size() == 0) begin
        report("unexpected item", response_o, 0);
      end else begin
        e = pending_resp.pop_front();
        if (response_o !== e.resp) report("response", response_o, e.resp);
        if (out_row_o !== e.row) report("out_row", out_row_o, e.row);
        if (out_col_o !== e.col) report("out_col", out_col_o, e.col);
        if (frame_last_o !== e.last) report("frame_last", frame_last_o, e.last);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIM) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    corner_t none;
    int unsigned sens;
    none = '{default: '0};
    // Flat 5x5 frame of full-scale pixels: no gradient, so a zero response
    foreach (dir_tbl[i]) dir_tbl[i] = '{px: 8'd255, typed: 1'b0, want: none};
    dir_tbl[24].typed = 1'b1;
    dir_tbl[24].want  = '{resp: 48'd0, row: 12'd2, col: 10'd2, last: 1'b1};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest frame at the reset sensitivity
    write_cfg(CFG_COLS, 16'd3);
    write_cfg(CFG_ROWS, 16'd3);
    foreach (dir_tbl[i]) send_pixel(dir_tbl[i].px, dir_tbl[i].typed, dir_tbl[i].want);
    frames_run++;

    // Wide frame with no idling, then a wide frame at full sensitivity
    calm = 1'b1;
    setup_frame(24, 6, 2621);
    stream_frame(2);
    calm = 1'b0;
    setup_frame(12, 3, 65535);
    stream_frame(1);

    // Tall narrow frames at zero and half-scale sensitivity
    setup_frame(3, 40, 0);
    stream_frame(0);
    setup_frame(4, 20, 32768);
    stream_frame(1);

    // Shrink the frame while counters sit mid-frame
    setup_frame(8, 6, 2621);
    repeat (43) send_pixel(pick_pixel(0, 0, 0), 1'b0, none);
    setup_frame(3, 3, 1000);
    stream_frame(0);

    // Random frames, mostly small, with clamped and extreme settings mixed in
    while (pixels_sent < RAND_PIX) begin
      case ($urandom_range(0, 3))
        0: sens = 0;
        1: sens = 65535;
        2: sens = 2621;
        default: sens = $urandom_range(0, 65535);
      endcase
      setup_frame($urandom_range(0, 10), $urandom_range(0, 8), sens);
      calm = ($urandom_range(0, 9) == 0);
      stream_frame($urandom_range(0, 2));
      calm = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("ran %0d frames of %0d pixels, %0d results checked, sizes from 3x3 up to",
             frames_run, pixels_sent, results_seen);
    $display("24 wide and 40 tall, with clamped sizes and extreme sensitivities");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
